>>> rtl/gscc_pkg.sv
// ----------------------------------------------------------------------------
// gscc_pkg
// Shared constants and types of the grid segment collision checker.
// ----------------------------------------------------------------------------
package gscc_pkg;

   localparam int MAP_DIM = 256;
   localparam int DIM_W   = $clog2(MAP_DIM);
   localparam int ADDR_W  = 2 * DIM_W;

   localparam logic [7:0] COST_LETHAL = 8'd254;

   // commands
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_POINT   = 2'd1;
   localparam logic [1:0] CMD_SEGMENT = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_MAP_VALID  = 3'd0;
   localparam logic [2:0] CSR_MAP_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_MAP_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_CELL_SIZE  = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_X   = 3'd4;
   localparam logic [2:0] CSR_ORIGIN_Y   = 3'd5;

   // iteration counts of the shared unit
   localparam logic [5:0] SQRT_IT  = 6'd26;  // root of a 49-bit square sum
   localparam logic [5:0] STEPS_IT = 6'd25;  // root / cell size
   localparam logic [5:0] STEP_IT  = 6'd33;  // scaled step component
   localparam logic [5:0] CELL_IT  = 6'(DIM_W);
   localparam int SQRT_TOP_BIT     = 50;

   typedef struct packed {
      logic        start;
      logic        is_sqrt;
      logic [5:0]  iters;
      logic [63:0] num;
      logic [63:0] den;
   } arith_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] res;
   } arith_rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic [ADDR_W-1:0] raddr;
   } grid_port_type;

endpackage

>>> rtl/gscc_arith.sv
// ----------------------------------------------------------------------------
// gscc_arith
// Shared compare-subtract unit: restoring divide or integer square root,
// one bit per cycle.
// ----------------------------------------------------------------------------
module gscc_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  gscc_pkg::arith_cmd_type cmd,
   output gscc_pkg::arith_rsp_type rsp
);

   localparam int SQRT_BIT_SHIFT = gscc_pkg::SQRT_TOP_BIT;

   logic        busy_ff;
   logic        done_ff;
   logic        sqrt_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff;
   logic [63:0] dsh_ff;
   logic [63:0] res_ff;
   logic [63:0] opnd;
   logic [63:0] diff;
   logic        ge;

   always_comb begin
      opnd = sqrt_ff ? (res_ff + dsh_ff) : dsh_ff;
      ge   = (rem_ff >= opnd);
      diff = rem_ff - opnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            sqrt_ff <= cmd.is_sqrt;
            cnt_ff  <= cmd.iters;
            rem_ff  <= cmd.num;
            res_ff  <= '0;
            if (cmd.is_sqrt) begin
               dsh_ff <= 64'(1) << SQRT_BIT_SHIFT;
            end else begin
               dsh_ff <= cmd.den << (cmd.iters - 6'd1);
            end
         end else if (busy_ff) begin
            if (ge) begin
               rem_ff <= diff;
            end
            if (sqrt_ff) begin
               res_ff <= ge ? ((res_ff >> 1) + dsh_ff) : (res_ff >> 1);
               dsh_ff <= dsh_ff >> 2;
            end else begin
               res_ff <= {res_ff[62:0], ge};
               dsh_ff <= dsh_ff >> 1;
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule

>>> rtl/gscc_grid.sv
// ----------------------------------------------------------------------------
// gscc_grid
// Cost grid memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gscc_grid (
   input  logic                    clock,
   input  gscc_pkg::grid_port_type port,
   output logic [7:0]              rdata
);

   logic [7:0] mem_ff [gscc_pkg::MAP_DIM * gscc_pkg::MAP_DIM];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (port.we) begin
         mem_ff[port.waddr] <= port.wdata;
      end
      rdata_ff <= mem_ff[port.raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/grid_segment_collision_check_core.sv
// ----------------------------------------------------------------------------
// grid_segment_collision_check_core
// Occupancy grid with point and line-of-sight collision queries.
// ----------------------------------------------------------------------------
// The block holds a MAP_DIM x MAP_DIM byte cost grid loaded by write
// transactions (cmd 0, no response). A point query (cmd 1) maps start_x/y to
// a cell and returns one response; a segment query (cmd 2) samples the
// interior of the segment at one cell length apart and stops at the first
// sample that hits a cost of 254 or more or lands off the map. All arithmetic
// runs on one shared compare-subtract unit (divide and square root, one bit a
// cycle) plus one 24x24 multiplier, so the block takes one transaction at a
// time. A point query divides each offset by the cell size, skipping the
// division for an offset that is not positive. A segment query first runs
// its setup (the 26-step root, a 25-step and two 33-step divides), then one
// point check for each sample, up to one sample per cell of segment length.
// A segment shorter than one cell skips the root and divides and checks only
// its end point.
// Configuration writes are accepted at any time and must only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
module grid_segment_collision_check_core (
   input  logic         clock,
   input  logic         reset,
   // request: cmd[1:0], start_x[25:2], start_y[49:26], end_x[73:50],
   //          end_y[97:74], cell_col[105:98], cell_row[113:106],
   //          cell_cost[121:114], zero pad [127:122]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,
   // response: collides[0], left_map[1], zero pad [7:2]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   // configuration write
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata
);

   localparam int DIM_W  = gscc_pkg::DIM_W;
   localparam int ADDR_W = gscc_pkg::ADDR_W;

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_CS2, S_SHORT, S_SQRT, S_STEPS,
      S_MULX, S_DIVX, S_WDX, S_MULY, S_DIVY, S_WDY, S_LOOP,
      S_LIMX, S_CHKX, S_WMX, S_LIMY, S_CHKY, S_WMY, S_READ, S_COST, S_DONE
   } state_type;

   // request fields
   logic [1:0]         req_cmd;
   logic signed [23:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic [7:0]         req_cell_col, req_cell_row, req_cell_cost;

   assign req_cmd       = req_tdata[1:0];
   assign req_start_x   = req_tdata[25:2];
   assign req_start_y   = req_tdata[49:26];
   assign req_end_x     = req_tdata[73:50];
   assign req_end_y     = req_tdata[97:74];
   assign req_cell_col  = req_tdata[105:98];
   assign req_cell_row  = req_tdata[113:106];
   assign req_cell_cost = req_tdata[121:114];

   // configuration registers
   logic               map_valid_ff;
   logic [8:0]         map_width_ff, map_height_ff;
   logic [15:0]        cell_size_ff;
   logic signed [23:0] origin_x_ff, origin_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff  <= 1'b0;
         map_width_ff  <= 9'd256;
         map_height_ff <= 9'd256;
         cell_size_ff  <= 16'd204;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            gscc_pkg::CSR_MAP_VALID:  map_valid_ff  <= csr_wdata[0];
            gscc_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata[8:0];
            gscc_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata[8:0];
            gscc_pkg::CSR_CELL_SIZE:  cell_size_ff  <= csr_wdata[15:0];
            gscc_pkg::CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata;
            gscc_pkg::CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // effective map geometry: zero cell size acts as one raw unit, oversized
   // map dimensions clamp to the grid
   logic [15:0]  cs_eff;
   logic [23:0]  w_eff, h_eff;

   always_comb begin
      cs_eff = (cell_size_ff == 16'd0) ? 16'd1 : cell_size_ff;
      w_eff  = (24'(map_width_ff) > 24'(gscc_pkg::MAP_DIM)) ?
               24'(gscc_pkg::MAP_DIM) : 24'(map_width_ff);
      h_eff  = (24'(map_height_ff) > 24'(gscc_pkg::MAP_DIM)) ?
               24'(gscc_pkg::MAP_DIM) : 24'(map_height_ff);
   end

   // working registers
   state_type          state_ff;
   logic               seg_ff;
   logic signed [23:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [24:0] dx_ff, dy_ff;
   logic [48:0]        d2_ff;
   logic [24:0]        r_ff;
   logic [24:0]        steps_ff;
   logic [24:0]        n_ff;
   logic signed [33:0] stx_ff, sty_ff;
   logic signed [43:0] accx_ff, accy_ff;
   logic signed [31:0] px_ff, py_ff;
   logic [DIM_W-1:0]   mx_ff, my_ff;
   logic [47:0]        prod_ff;
   logic               hit_ff, off_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_bits_ff;

   // segment magnitudes (differences of 24-bit values fit 24 bits unsigned)
   logic [23:0] adx, ady;
   assign adx = dx_ff[24] ? 24'(-dx_ff) : dx_ff[23:0];
   assign ady = dy_ff[24] ? 24'(-dy_ff) : dy_ff[23:0];

   // shared multiplier, operands chosen by state, product registered
   logic [23:0] mul_a, mul_b;

   always_comb begin
      case (state_ff)
         S_SQX:   begin mul_a = adx;          mul_b = adx;          end
         S_SQY:   begin mul_a = ady;          mul_b = ady;          end
         S_CS2:   begin mul_a = 24'(cs_eff);  mul_b = 24'(cs_eff);  end
         S_MULX:  begin mul_a = 24'(cs_eff);  mul_b = adx;          end
         S_MULY:  begin mul_a = 24'(cs_eff);  mul_b = ady;          end
         S_LIMX:  begin mul_a = w_eff;        mul_b = 24'(cs_eff);  end
         S_LIMY:  begin mul_a = h_eff;        mul_b = 24'(cs_eff);  end
         default: begin mul_a = '0;           mul_b = '0;           end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sample rounding: accumulated step has 16 extra fraction bits
   logic [43:0]        magx, magy;
   logic [27:0]        rmx, rmy;
   logic signed [31:0] rndx, rndy;

   always_comb begin
      magx = accx_ff[43] ? 44'(-accx_ff) : accx_ff;
      magy = accy_ff[43] ? 44'(-accy_ff) : accy_ff;
      rmx  = 28'((magx + 44'd32768) >> 16);
      rmy  = 28'((magy + 44'd32768) >> 16);
      rndx = accx_ff[43] ? -$signed(32'(rmx)) : $signed(32'(rmx));
      rndy = accy_ff[43] ? -$signed(32'(rmy)) : $signed(32'(rmy));
   end

   // point-to-cell range checks
   logic signed [31:0] numx, numy, ncs, limit;
   logic               offx, offy;

   always_comb begin
      numx  = px_ff - 32'(origin_x_ff);
      numy  = py_ff - 32'(origin_y_ff);
      ncs   = -$signed({16'd0, cs_eff});
      limit = $signed({1'b0, prod_ff[30:0]});
      offx  = (numx <= ncs) || (numx >= limit) || (w_eff == 24'd0);
      offy  = (numy <= ncs) || (numy >= limit) || (h_eff == 24'd0);
   end

   // shared divide / root unit
   gscc_pkg::arith_cmd_type arith_cmd;
   gscc_pkg::arith_rsp_type arith_rsp;

   always_comb begin
      arith_cmd       = '0;
      case (state_ff)
         S_SHORT: begin
            arith_cmd.start   = (d2_ff >= 49'(prod_ff));
            arith_cmd.is_sqrt = 1'b1;
            arith_cmd.iters   = gscc_pkg::SQRT_IT;
            arith_cmd.num     = 64'(d2_ff);
         end
         S_SQRT: begin
            arith_cmd.start = arith_rsp.done;
            arith_cmd.iters = gscc_pkg::STEPS_IT;
            arith_cmd.num   = 64'(arith_rsp.res[24:0]);
            arith_cmd.den   = 64'(cs_eff);
         end
         S_DIVX, S_DIVY: begin
            arith_cmd.start = 1'b1;
            arith_cmd.iters = gscc_pkg::STEP_IT;
            arith_cmd.num   = 64'(prod_ff[39:0]) << 16;
            arith_cmd.den   = 64'(r_ff);
         end
         S_CHKX: begin
            arith_cmd.start = !offx && (numx > 32'sd0);
            arith_cmd.iters = gscc_pkg::CELL_IT;
            arith_cmd.num   = 64'(numx[30:0]);
            arith_cmd.den   = 64'(cs_eff);
         end
         S_CHKY: begin
            arith_cmd.start = !offy && (numy > 32'sd0);
            arith_cmd.iters = gscc_pkg::CELL_IT;
            arith_cmd.num   = 64'(numy[30:0]);
            arith_cmd.den   = 64'(cs_eff);
         end
         default: ;
      endcase
   end

   gscc_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .rsp   (arith_rsp)
   );

   // cost grid
   logic                     req_fire;
   logic [DIM_W+7:0]         col_wide, row_wide;
   gscc_pkg::grid_port_type  grid_port;
   logic [7:0]               grid_rdata;
   logic signed [33:0]       q_signed_x, q_signed_y;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign col_wide   = (DIM_W + 8)'(req_cell_col);
   assign row_wide   = (DIM_W + 8)'(req_cell_row);

   always_comb begin
      grid_port.we    = req_fire && (req_cmd == gscc_pkg::CMD_WRITE) &&
                        (col_wide < (DIM_W + 8)'(gscc_pkg::MAP_DIM)) &&
                        (row_wide < (DIM_W + 8)'(gscc_pkg::MAP_DIM));
      grid_port.waddr = {row_wide[DIM_W-1:0], col_wide[DIM_W-1:0]};
      grid_port.wdata = req_cell_cost;
      grid_port.raddr = {my_ff, mx_ff};
   end

   gscc_grid u_grid (
      .clock (clock),
      .port  (grid_port),
      .rdata (grid_rdata)
   );

   // signed step component: truncation toward zero follows the sign of d
   assign q_signed_x = dx_ff[24] ? -$signed({1'b0, arith_rsp.res[32:0]})
                                 :  $signed({1'b0, arith_rsp.res[32:0]});
   assign q_signed_y = dy_ff[24] ? -$signed({1'b0, arith_rsp.res[32:0]})
                                 :  $signed({1'b0, arith_rsp.res[32:0]});

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response once taken, unless a new one loads this cycle
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  sx_ff  <= req_start_x;
                  sy_ff  <= req_start_y;
                  ex_ff  <= req_end_x;
                  ey_ff  <= req_end_y;
                  dx_ff  <= 25'(req_end_x) - 25'(req_start_x);
                  dy_ff  <= 25'(req_end_y) - 25'(req_start_y);
                  px_ff  <= 32'(req_start_x);
                  py_ff  <= 32'(req_start_y);
                  seg_ff <= 1'b0;
                  hit_ff <= 1'b0;
                  off_ff <= 1'b0;
                  if (req_cmd == gscc_pkg::CMD_POINT ||
                      req_cmd == gscc_pkg::CMD_SEGMENT) begin
                     if (!map_valid_ff) begin
                        state_ff <= S_DONE;
                     end else if (req_cmd == gscc_pkg::CMD_POINT) begin
                        state_ff <= S_LIMX;
                     end else begin
                        state_ff <= S_SQX;
                     end
                  end
               end
            end
            S_SQX: state_ff <= S_SQY;
            S_SQY: begin
               d2_ff    <= prod_ff[48:0];
               state_ff <= S_CS2;
            end
            S_CS2: begin
               d2_ff    <= d2_ff + 49'(prod_ff);
               state_ff <= S_SHORT;
            end
            S_SHORT: begin
               if (d2_ff < 49'(prod_ff)) begin
                  // shorter than one cell: check the end point only
                  px_ff    <= 32'(ex_ff);
                  py_ff    <= 32'(ey_ff);
                  state_ff <= S_LIMX;
               end else begin
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (arith_rsp.done) begin
                  r_ff     <= arith_rsp.res[24:0];
                  state_ff <= S_STEPS;
               end
            end
            S_STEPS: begin
               if (arith_rsp.done) begin
                  steps_ff <= arith_rsp.res[24:0];
                  state_ff <= S_MULX;
               end
            end
            S_MULX: state_ff <= S_DIVX;
            S_DIVX: state_ff <= S_WDX;
            S_WDX: begin
               if (arith_rsp.done) begin
                  stx_ff   <= q_signed_x;
                  state_ff <= S_MULY;
               end
            end
            S_MULY: state_ff <= S_DIVY;
            S_DIVY: state_ff <= S_WDY;
            S_WDY: begin
               if (arith_rsp.done) begin
                  sty_ff   <= q_signed_y;
                  accx_ff  <= 44'(stx_ff);
                  accy_ff  <= 44'(q_signed_y);
                  n_ff     <= 25'd1;
                  state_ff <= S_LOOP;
               end
            end
            S_LOOP: begin
               if (n_ff < steps_ff) begin
                  px_ff    <= 32'(sx_ff) + rndx;
                  py_ff    <= 32'(sy_ff) + rndy;
                  seg_ff   <= 1'b1;
                  state_ff <= S_LIMX;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_LIMX: state_ff <= S_CHKX;
            S_CHKX: begin
               if (offx) begin
                  hit_ff   <= 1'b1;
                  off_ff   <= 1'b1;
                  state_ff <= S_DONE;
               end else if (numx > 32'sd0) begin
                  state_ff <= S_WMX;
               end else begin
                  // small negative offsets truncate to column zero
                  mx_ff    <= '0;
                  state_ff <= S_LIMY;
               end
            end
            S_WMX: begin
               if (arith_rsp.done) begin
                  mx_ff    <= arith_rsp.res[DIM_W-1:0];
                  state_ff <= S_LIMY;
               end
            end
            S_LIMY: state_ff <= S_CHKY;
            S_CHKY: begin
               if (offy) begin
                  hit_ff   <= 1'b1;
                  off_ff   <= 1'b1;
                  state_ff <= S_DONE;
               end else if (numy > 32'sd0) begin
                  state_ff <= S_WMY;
               end else begin
                  my_ff    <= '0;
                  state_ff <= S_READ;
               end
            end
            S_WMY: begin
               if (arith_rsp.done) begin
                  my_ff    <= arith_rsp.res[DIM_W-1:0];
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_COST;
            S_COST: begin
               if (grid_rdata >= gscc_pkg::COST_LETHAL) begin
                  hit_ff   <= 1'b1;
                  state_ff <= S_DONE;
               end else if (seg_ff) begin
                  // advance to the next sample
                  n_ff     <= n_ff + 25'd1;
                  accx_ff  <= accx_ff + 44'(stx_ff);
                  accy_ff  <= accy_ff + 44'(sty_ff);
                  state_ff <= S_LOOP;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bits_ff  <= {hit_ff && off_ff, hit_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_bits_ff};

endmodule

>>> dv/grid_segment_collision_check_core_tb.sv
// ----------------------------------------------------------------------------
// grid_segment_collision_check_core_tb
// Self-checking bench for the occupancy grid collision checker. Load the grid
// with write transactions, run point and segment queries under several map
// settings, predict every response in the bench and compare field by field.
// ----------------------------------------------------------------------------
class collision_scoreboard;
   bit [7:0]   cost_grid [gscc_pkg::MAP_DIM*gscc_pkg::MAP_DIM];
   bit         map_valid;
   bit [8:0]   map_width;
   bit [8:0]   map_height;
   bit [15:0]  cell_size;
   bit [23:0]  origin_x;
   bit [23:0]  origin_y;
   bit [1:0]   hit_queue[$];
   int         error_count;

   function void set_reg(bit [2:0] idx, bit [23:0] value);
      case (idx)
         gscc_pkg::CSR_MAP_VALID:  map_valid  = value[0];
         gscc_pkg::CSR_MAP_WIDTH:  map_width  = value[8:0];
         gscc_pkg::CSR_MAP_HEIGHT: map_height = value[8:0];
         gscc_pkg::CSR_CELL_SIZE:  cell_size  = value[15:0];
         gscc_pkg::CSR_ORIGIN_X:   origin_x   = value;
         gscc_pkg::CSR_ORIGIN_Y:   origin_y   = value;
         default: ;
      endcase
   endfunction

   function longint cell_edge();
      return (cell_size == 0) ? 1 : longint'(cell_size);
   endfunction

   // Map a world point to a cell; flag off-map cells.
   function bit point_blocked(longint wx, longint wy, ref bit off);
      longint cs, mx, my, w, h;
      cs = cell_edge();
      mx = (wx - longint'($signed(origin_x))) / cs;
      my = (wy - longint'($signed(origin_y))) / cs;
      w  = (map_width  > gscc_pkg::MAP_DIM) ? gscc_pkg::MAP_DIM : map_width;
      h  = (map_height > gscc_pkg::MAP_DIM) ? gscc_pkg::MAP_DIM : map_height;
      if (mx < 0 || my < 0 || mx >= w || my >= h) begin
         off = 1;
         return 1;
      end
      return cost_grid[my*gscc_pkg::MAP_DIM + mx] >= gscc_pkg::COST_LETHAL;
   endfunction

   function longint floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function longint round_q16(longint v);
      if (v < 0) return -((-v + 32768) >>> 16);
      return (v + 32768) >>> 16;
   endfunction

   function bit segment_blocked(longint sx, longint sy, longint ex, longint ey,
                                ref bit off);
      longint cs, dx, dy, r, steps, stx, sty;
      longint unsigned d2;
      cs = cell_edge();
      dx = ex - sx;
      dy = ey - sy;
      d2 = dx*dx + dy*dy;
      if (d2 < cs*cs) return point_blocked(ex, ey, off);
      r = floor_root(d2);
      steps = r / cs;
      stx = (cs * dx * 65536) / r;
      sty = (cs * dy * 65536) / r;
      for (longint n = 1; n < steps; n++)
         if (point_blocked(sx + round_q16(n*stx), sy + round_q16(n*sty), off))
            return 1;
      return 0;
   endfunction

   // Note one accepted request; queue the response it should cause.
   function void note_request(bit [127:0] d);
      bit [1:0] cmd;
      bit hit, off;
      cmd = d[1:0];
      hit = 0;
      off = 0;
      if (cmd == gscc_pkg::CMD_WRITE) begin
         cost_grid[d[113:106]*gscc_pkg::MAP_DIM + d[105:98]] = d[121:114];
         return;
      end
      if (cmd != gscc_pkg::CMD_POINT && cmd != gscc_pkg::CMD_SEGMENT) return;
      if (map_valid) begin
         if (cmd == gscc_pkg::CMD_POINT)
            hit = point_blocked($signed(d[25:2]), $signed(d[49:26]), off);
         else
            hit = segment_blocked($signed(d[25:2]), $signed(d[49:26]),
                                  $signed(d[73:50]), $signed(d[97:74]), off);
      end
      hit_queue.push_back({hit & off, hit});
   endfunction

   function void check_response(bit [7:0] d);
      bit [1:0] exp;
      if (hit_queue.size() == 0) begin
         $error("response with none expected: %h", d);
         error_count++;
         return;
      end
      exp = hit_queue.pop_front();
      if (d[0] !== exp[0]) begin
         $error("collides: expected %0d actual %0d", exp[0], d[0]);
         error_count++;
      end
      if (d[1] !== exp[1]) begin
         $error("left_map: expected %0d actual %0d", exp[1], d[1]);
         error_count++;
      end
      if (d[7:2] !== 6'd0) begin
         $error("pad: expected 0 actual %h", d[7:2]);
         error_count++;
      end
   endfunction
endclass

module grid_segment_collision_check_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 200000;
   localparam int CLEAR_DIM   = 20;   // corner of the grid that maps may use

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // cmd, start_x, start_y, end_x, end_y, col, row, cost
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;   // collides, left_map, zero pad
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [23:0]  csr_wdata;

   collision_scoreboard tracker;
   bit  quiet_tail;       // no idling in the last part of the run
   bit  hold_sink;        // long receiver hold-off request
   int  idle_cycles;

   grid_segment_collision_check_core u_top (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stall bursts, plus one long hold-off.
   initial begin
      int gap;
      rsp_tready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_sink) begin
            rsp_tready <= 0;
            repeat (3000) @(posedge clock);
            hold_sink = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // Check every accepted response.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
   end

   // Watchdog: count cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [23:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_reg(idx, value);
      csr_valid <= 0;
   endtask

   // Offer one request and hold it until the block takes it.
   task automatic send_request(logic [127:0] d);
      int gap;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(d);
   endtask

   task automatic end_stream();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [127:0] pack_req(logic [1:0] cmd, logic [23:0] sx,
         logic [23:0] sy, logic [23:0] ex, logic [23:0] ey, logic [7:0] col,
         logic [7:0] row, logic [7:0] cost);
      return {6'd0, cost, row, col, ey, ex, sy, sx, cmd};
   endfunction

   task automatic write_cell(logic [7:0] col, logic [7:0] row, logic [7:0] cost);
      send_request(pack_req(gscc_pkg::CMD_WRITE, 24'($urandom), 24'($urandom),
                            24'($urandom), 24'($urandom), col, row, cost));
   endtask

   // Drain all pending responses before touching the registers.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (tracker.hit_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Random coordinate near the x origin, sometimes anywhere.
   function automatic logic [23:0] coord(int span);
      if ($urandom_range(0, 9) == 0) return 24'($urandom);
      return 24'($signed(tracker.origin_x) + $urandom_range(0, span) - span / 10);
   endfunction

   // Short segments near the origin so the walk stays cheap.
   task automatic random_query(int span);
      logic [23:0] sx, sy, ex, ey;
      logic [1:0]  cmd;
      sx = coord(span);
      sy = coord(span);
      ex = sx + 24'($signed($urandom_range(0, span)) - span / 2);
      ey = sy + 24'($signed($urandom_range(0, span)) - span / 2);
      if ($urandom_range(0, 9) == 0) begin
         ex = 24'($urandom);
         ey = 24'($urandom);
      end
      case ($urandom_range(0, 9))
         0, 1: cmd = gscc_pkg::CMD_WRITE;
         2, 3, 4: cmd = gscc_pkg::CMD_POINT;
         5: cmd = 2'd3;
         default: cmd = gscc_pkg::CMD_SEGMENT;
      endcase
      send_request(pack_req(cmd, sx, sy, ex, ey, 8'($urandom), 8'($urandom),
                            8'($urandom)));
   endtask

   initial begin
      int span;
      tracker = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_wdata = '0;
      quiet_tail = 0;
      hold_sink = 0;
      tracker.map_valid = 0;
      tracker.map_width = 256;
      tracker.map_height = 256;
      tracker.cell_size = 204;
      tracker.origin_x = 0;
      tracker.origin_y = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // With no map loaded nothing collides; query before any grid write.
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'h7FFFFF, 24'h800000,
                            0, 0, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_SEGMENT, 24'h800000, 24'h800000,
                            24'h7FFFFF, 24'h7FFFFF, 0, 0, 0));
      drain();

      // Clear the corner that every query below reads from, so no query
      // reads an unwritten cell.
      for (int r = 0; r < CLEAR_DIM; r++)
         for (int c = 0; c < CLEAR_DIM; c++)
            write_cell(8'(c), 8'(r), 8'd0);
      write_cell(8'd255, 8'd255, 8'd255);
      write_cell(8'd0, 8'd0, 8'd254);
      write_cell(8'd1, 8'd0, 8'd253);
      write_cell(8'd5, 8'd5, 8'd254);
      drain();

      csr_write(gscc_pkg::CSR_MAP_VALID, 24'd1);
      csr_write(gscc_pkg::CSR_MAP_WIDTH, 24'd16);
      csr_write(gscc_pkg::CSR_MAP_HEIGHT, 24'd16);
      csr_write(gscc_pkg::CSR_CELL_SIZE, 24'd4096);
      csr_write(gscc_pkg::CSR_ORIGIN_X, 24'd0);
      csr_write(gscc_pkg::CSR_ORIGIN_Y, 24'd0);
      // Directed: lethal, near-lethal, off-map at negative x and at large y, short
      // and long segments, unknown command, extremes.
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'h000800, 24'h000800,
                            0, 0, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'h001800, 24'h000800,
                            0, 0, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'hFFF000, 24'h000800,
                            0, 0, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'h000800, 24'h010000,
                            0, 0, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'h7FFFFF, 24'h7FFFFF,
                            0, 0, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_SEGMENT, 24'h001000, 24'h001000,
                            24'h001100, 24'h001100, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_SEGMENT, 24'h000800, 24'h000800,
                            24'h00F800, 24'h00F800, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_SEGMENT, 24'h002000, 24'h008000,
                            24'h00E000, 24'h001000, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_SEGMENT, 24'h008000, 24'h008000,
                            24'h020000, 24'h008000, 0, 0, 0));
      send_request(pack_req(2'd3, 24'h001000, 24'h001000, 0, 0, 0, 0, 0));
      drain();

      // Odd settings: zero cell size, zero map, oversized map, offsets.
      csr_write(gscc_pkg::CSR_CELL_SIZE, 24'd0);
      csr_write(gscc_pkg::CSR_MAP_WIDTH, 24'd0);
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'd3, 24'd3, 0, 0, 0, 0, 0));
      drain();
      csr_write(gscc_pkg::CSR_MAP_WIDTH, 24'd511);
      csr_write(gscc_pkg::CSR_MAP_HEIGHT, 24'd300);
      csr_write(gscc_pkg::CSR_CELL_SIZE, 24'd65535);
      csr_write(gscc_pkg::CSR_ORIGIN_X, 24'h800000);
      csr_write(gscc_pkg::CSR_ORIGIN_Y, 24'h7FFFFF);
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'h7FFFFF, 24'h7FFFFF,
                            0, 0, 0, 0, 0));
      send_request(pack_req(gscc_pkg::CMD_POINT, 24'h800000, 24'h7FFFFF,
                            0, 0, 0, 0, 0));
      drain();

      // Random phases over several settings.
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(gscc_pkg::CSR_MAP_VALID, 24'(ph != 3));
         csr_write(gscc_pkg::CSR_MAP_WIDTH, 24'($urandom_range(1, CLEAR_DIM)));
         csr_write(gscc_pkg::CSR_MAP_HEIGHT,
                   (ph == 5) ? 24'(CLEAR_DIM) : 24'($urandom_range(1, CLEAR_DIM)));
         csr_write(gscc_pkg::CSR_CELL_SIZE,
                   (ph == 4) ? 24'd65535 : 24'($urandom_range(2048, 8192)));
         csr_write(gscc_pkg::CSR_ORIGIN_X,
                   24'($signed($urandom_range(0, 65536)) - 32768));
         csr_write(gscc_pkg::CSR_ORIGIN_Y,
                   24'($signed($urandom_range(0, 65536)) - 32768));
         span = 24 * int'(tracker.cell_size);
         for (int i = 0; i < 30; i++)
            write_cell(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                       8'($urandom_range(250, 255)));
         if (ph == 1) hold_sink = 1;   // sender keeps offering while sink holds
         if (ph == 5) quiet_tail = 1;
         for (int i = 0; i < 150; i++) random_query(span);
         drain();
      end

      repeat (100) @(posedge clock);
      if (tracker.error_count == 0 && tracker.hit_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
